// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define SQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge.
`define SQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/sqhit_pkg.sv =====
package sqhit_pkg;

  // fixed field widths of the obstacle registers
  localparam int HALF_W    = 15;
  localparam int EPS_W     = 16;
  // full edge length 2*edge_half as a signed value
  localparam int SIDE_W    = HALF_W + 2;
  localparam int REG_IDX_W = 3;
  localparam int NUM_EDGES = 4;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X         = 3'd0,
    REG_CENTER_Y         = 3'd1,
    REG_POINT_HALF       = 3'd2,
    REG_EDGE_HALF        = 3'd3,
    REG_PARALLEL_EPSILON = 3'd4
  } cfg_reg_e;

  // edge order: left, bottom, right, top
  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_TOP    = 2'd3
  } edge_e;

endpackage

// ===== sv/segment_square_hit_test_core.sv =====
// Segment / axis-aligned square hit test.
// Query channel: in_valid_i/in_ready_o with kind_i, p0_x_i, p0_y_i, p1_x_i,
// p1_y_i. Kind 0 tests segment p0-p1 against the edges of the square, kind 1
// tests whether p0 lies strictly inside the point square.
// Result channel: out_valid_o/out_ready_i with hit_o, one result per query,
// in query order.
// Obstacle registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, one
// register per cycle; write them only while no query is in flight.
// Each query passes through four register stages: corner and difference stage,
// multiplier stage, determinant/numerator stage, and the compare stage that feeds
// the output register. One query is accepted every cycle while the output
// register is free or taken.
// A stalled receiver freezes all stages at once, and in_ready_o drops until
// the output register is taken, so no transaction is lost or repeated.
// Reset clears all valid bits and sets every obstacle register to zero.
`include "assert_macros.svh"

module segment_square_hit_test_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sqhit_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [((COORD_WIDTH > sqhit_pkg::EPS_W) ?
                 COORD_WIDTH : sqhit_pkg::EPS_W)-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   kind_i,
  input  logic signed [COORD_WIDTH-1:0]          p0_x_i,
  input  logic signed [COORD_WIDTH-1:0]          p0_y_i,
  input  logic signed [COORD_WIDTH-1:0]          p1_x_i,
  input  logic signed [COORD_WIDTH-1:0]          p1_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   hit_o
);

  localparam int BW  = (COORD_WIDTH > sqhit_pkg::EPS_W) ? COORD_WIDTH : sqhit_pkg::EPS_W;
  localparam int SW  = BW + 1;              // corner coordinates
  localparam int DW  = SW + 1;              // point minus corner
  localparam int VW  = COORD_WIDTH + 1;     // segment direction
  localparam int HW  = sqhit_pkg::SIDE_W;   // edge length
  localparam int PW  = DW + VW;             // d * v products
  localparam int QW  = HW + VW;             // h * v products
  localparam int RW  = HW + DW;             // h * d products
  localparam int NW  = PW + 1;              // numerators and determinants
  localparam int NE  = sqhit_pkg::NUM_EDGES;
  localparam logic signed [NW-1:0] ZERO = '0;

  // obstacle registers
  logic signed [COORD_WIDTH-1:0]       center_x_q, center_y_q;
  logic [sqhit_pkg::HALF_W-1:0]        point_half_q, edge_half_q;
  logic [sqhit_pkg::EPS_W-1:0]         eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      point_half_q <= '0;
      edge_half_q  <= '0;
      eps_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sqhit_pkg::REG_CENTER_X:         center_x_q   <= cfg_data_i[COORD_WIDTH-1:0];
        sqhit_pkg::REG_CENTER_Y:         center_y_q   <= cfg_data_i[COORD_WIDTH-1:0];
        sqhit_pkg::REG_POINT_HALF:       point_half_q <= cfg_data_i[sqhit_pkg::HALF_W-1:0];
        sqhit_pkg::REG_EDGE_HALF:        edge_half_q  <= cfg_data_i[sqhit_pkg::HALF_W-1:0];
        sqhit_pkg::REG_PARALLEL_EPSILON: eps_q        <= cfg_data_i[sqhit_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves when the output slot is free or taken
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: corners, differences, point test
  logic signed [SW-1:0] cx_s, cy_s, eh_s, ph_s;
  logic signed [SW-1:0] xl, xr, yb, yt;
  logic signed [DW-1:0] dxl_d, dxr_d, dyb_d, dyt_d;
  logic signed [VW-1:0] vpx_d, vpy_d;
  logic signed [HW-1:0] h_d;
  logic                 pt_d;

  always_comb begin
    cx_s  = SW'(center_x_q);
    cy_s  = SW'(center_y_q);
    eh_s  = SW'(signed'({1'b0, edge_half_q}));
    ph_s  = SW'(signed'({1'b0, point_half_q}));
    xl    = cx_s - eh_s;
    xr    = cx_s + eh_s;
    yb    = cy_s - eh_s;
    yt    = cy_s + eh_s;
    dxl_d = DW'(p0_x_i) - DW'(xl);
    dxr_d = DW'(p0_x_i) - DW'(xr);
    dyb_d = DW'(p0_y_i) - DW'(yb);
    dyt_d = DW'(p0_y_i) - DW'(yt);
    vpx_d = VW'(p1_x_i) - VW'(p0_x_i);
    vpy_d = VW'(p1_y_i) - VW'(p0_y_i);
    h_d   = signed'({1'b0, edge_half_q, 1'b0});
    pt_d  = (SW'(p0_x_i) < cx_s + ph_s) && (SW'(p0_y_i) < cy_s + ph_s) &&
            (SW'(p0_x_i) > cx_s - ph_s) && (SW'(p0_y_i) > cy_s - ph_s);
  end

  logic                 kind1_q, pt1_q;
  logic signed [DW-1:0] dxl1_q, dxr1_q, dyb1_q, dyt1_q;
  logic signed [VW-1:0] vpx1_q, vpy1_q;
  logic signed [HW-1:0] h1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= kind_i;
      pt1_q   <= pt_d;
      dxl1_q  <= dxl_d;
      dxr1_q  <= dxr_d;
      dyb1_q  <= dyb_d;
      dyt1_q  <= dyt_d;
      vpx1_q  <= vpx_d;
      vpy1_q  <= vpy_d;
      h1_q    <= h_d;
    end
  end

  // ---------------- stage 2: products
  logic                 kind2_q, pt2_q;
  logic signed [PW-1:0] xlvy2_q, xrvy2_q, ybvx2_q, ytvx2_q;
  logic signed [QW-1:0] hvx2_q, hvy2_q;
  logic signed [RW-1:0] hxl2_q, hxr2_q, hyb2_q, hyt2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind2_q <= kind1_q;
      pt2_q   <= pt1_q;
      xlvy2_q <= PW'(dxl1_q) * PW'(vpy1_q);
      xrvy2_q <= PW'(dxr1_q) * PW'(vpy1_q);
      ybvx2_q <= PW'(dyb1_q) * PW'(vpx1_q);
      ytvx2_q <= PW'(dyt1_q) * PW'(vpx1_q);
      hvx2_q  <= QW'(h1_q) * QW'(vpx1_q);
      hvy2_q  <= QW'(h1_q) * QW'(vpy1_q);
      hxl2_q  <= RW'(h1_q) * RW'(dxl1_q);
      hxr2_q  <= RW'(h1_q) * RW'(dxr1_q);
      hyb2_q  <= RW'(h1_q) * RW'(dyb1_q);
      hyt2_q  <= RW'(h1_q) * RW'(dyt1_q);
    end
  end

  // ---------------- stage 3: determinants and numerators per edge
  logic                 kind3_q, pt3_q;
  logic signed [NW-1:0] det3_q [NE];
  logic signed [NW-1:0] ns3_q  [NE];
  logic signed [NW-1:0] nt3_q  [NE];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind3_q <= kind2_q;
      pt3_q   <= pt2_q;
      det3_q[sqhit_pkg::EDGE_LEFT]   <= NW'(hvx2_q);
      det3_q[sqhit_pkg::EDGE_BOTTOM] <= NW'(hvy2_q);
      det3_q[sqhit_pkg::EDGE_RIGHT]  <= -NW'(hvx2_q);
      det3_q[sqhit_pkg::EDGE_TOP]    <= -NW'(hvy2_q);
      ns3_q[sqhit_pkg::EDGE_LEFT]    <= NW'(xlvy2_q) - NW'(ytvx2_q);
      ns3_q[sqhit_pkg::EDGE_BOTTOM]  <= NW'(xlvy2_q) - NW'(ybvx2_q);
      ns3_q[sqhit_pkg::EDGE_RIGHT]   <= NW'(xrvy2_q) - NW'(ybvx2_q);
      ns3_q[sqhit_pkg::EDGE_TOP]     <= NW'(xrvy2_q) - NW'(ytvx2_q);
      nt3_q[sqhit_pkg::EDGE_LEFT]    <= -NW'(hxl2_q);
      nt3_q[sqhit_pkg::EDGE_BOTTOM]  <= -NW'(hyb2_q);
      nt3_q[sqhit_pkg::EDGE_RIGHT]   <= NW'(hxr2_q);
      nt3_q[sqhit_pkg::EDGE_TOP]     <= NW'(hyt2_q);
    end
  end

  // ---------------- stage 4: range compares, result register
  function automatic logic in_unit(input logic signed [NW-1:0] num,
                                   input logic signed [NW-1:0] den,
                                   input logic                 pos);
    logic r;
    if (pos) begin
      r = (num >= ZERO) && (num <= den);
    end else begin
      r = (num <= ZERO) && (num >= den);
    end
    return r;
  endfunction

  logic signed [NW-1:0] eps_p, eps_n;
  logic [NE-1:0]        edge_hit;
  logic                 hit_d;

  always_comb begin
    eps_p = NW'(signed'({1'b0, eps_q}));
    eps_n = -eps_p;
    for (int e = 0; e < NE; e++) begin
      // near-parallel edges never hit
      edge_hit[e] = ((det3_q[e] > eps_p) || (det3_q[e] < eps_n)) &&
                    in_unit(ns3_q[e], det3_q[e], det3_q[e] > ZERO) &&
                    in_unit(nt3_q[e], det3_q[e], det3_q[e] > ZERO);
    end
    hit_d = kind3_q ? pt3_q : (|edge_hit);
  end

  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = v4_q;
  assign hit_o       = hit_q;

  `SQ_ASSERT(a_stall_freezes, clk_i, rst_ni, !adv |=> $stable({v1_q, v2_q, v3_q}),
             "pipeline moved during a stall")
  `SQ_ASSERT(a_out_from_s3, clk_i, rst_ni, $rose(out_valid_o) |-> $past(v3_q),
             "result appeared without a stage 3 transaction")
  `SQ_ASSERT(a_zero_det_no_hit, clk_i, rst_ni,
             (v3_q && adv && !kind3_q && det3_q[sqhit_pkg::EDGE_LEFT] == ZERO &&
              det3_q[sqhit_pkg::EDGE_BOTTOM] == ZERO &&
              det3_q[sqhit_pkg::EDGE_RIGHT] == ZERO &&
              det3_q[sqhit_pkg::EDGE_TOP] == ZERO) |=> !hit_o,
             "segment hit reported with all determinants zero")
  `SQ_ASSERT(a_point_result, clk_i, rst_ni,
             (v3_q && adv && kind3_q) |=> (hit_o == $past(pt3_q)),
             "point test result corrupted")

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int COORD_W        = 16;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AFTER     = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_QUERIES  = 60;
  localparam int PLAN_ROWS      = 24;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_POINT   = 1'b1
  } query_kind_e;

  // setup rows: a..e = center x, center y, point half, edge half, epsilon
  // query rows: a..d = p0 x, p0 y, p1 x, p1 y
  typedef struct packed {
    bit                 is_setup;
    query_kind_e        kind;
    logic [COORD_W-1:0] a, b, c, d, e;
    bit                 typed;
    bit                 hit;
  } plan_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sqhit_pkg::REG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0]              cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            kind_i;
  logic [COORD_W-1:0]              p0_x_i, p0_y_i, p1_x_i, p1_y_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            hit_o;

  // obstacle as the block should hold it
  longint obst_cx, obst_cy, obst_ph, obst_eh, obst_eps;

  bit     hit_expected_q[$];
  int     mismatches   = 0;
  int     results_seen = 0;
  int     send_calm    = 0;
  bit     quiet_tail   = 1'b0;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    // reset state: empty point square, zero-length edges
    '{1'b0, KIND_POINT,   16'd0,      16'd0,      16'd0,      16'd0,      16'd0, 1'b1, 1'b0},
    '{1'b0, KIND_SEGMENT, -16'sd100,  -16'sd100,  16'd100,    16'd100,    16'd0, 1'b1, 1'b0},
    '{1'b1, KIND_SEGMENT, 16'd0,      16'd0,      16'd160,    16'd160,    16'd0, 1'b0, 1'b0},
    // point test ignores p1
    '{1'b0, KIND_POINT,   16'd0,      16'd0,      16'h8000,   16'h7fff,   16'd0, 1'b1, 1'b1},
    // on the border: strict compare
    '{1'b0, KIND_POINT,   16'd160,    16'd0,      16'd0,      16'd0,      16'd0, 1'b1, 1'b0},
    '{1'b0, KIND_POINT,   16'd159,    -16'sd159,  16'd0,      16'd0,      16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, -16'sd320,  16'd0,      16'd320,    16'd0,      16'd0, 1'b0, 1'b0},
    // degenerate segment
    '{1'b0, KIND_SEGMENT, 16'd50,     16'd50,     16'd50,     16'd50,     16'd0, 1'b1, 1'b0},
    '{1'b0, KIND_SEGMENT, 16'd0,      16'd0,      16'd10,     16'd10,     16'd0, 1'b0, 1'b0},
    // ends exactly on a corner
    '{1'b0, KIND_SEGMENT, -16'sd320,  -16'sd320,  -16'sd160,  -16'sd160,  16'd0, 1'b0, 1'b0},
    // collinear with the left edge
    '{1'b0, KIND_SEGMENT, -16'sd160,  -16'sd320,  -16'sd160,  16'd320,    16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, -16'sd320,  16'd0,      -16'sd160,  16'd0,      16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, 16'h8000,   16'h8000,   16'h7fff,   16'h7fff,   16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_POINT,   16'h8000,   16'h7fff,   16'd0,      16'd0,      16'd0, 1'b1, 1'b0},
    '{1'b1, KIND_SEGMENT, 16'h7fff,   16'h8000,   16'h7fff,   16'h7fff,   16'hffff, 1'b0, 1'b0},
    '{1'b0, KIND_POINT,   16'h7fff,   16'h8000,   16'h8000,   16'h8000,   16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, 16'h8000,   16'h7fff,   16'h7fff,   16'h8000,   16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, 16'd0,      16'd0,      16'h7fff,   16'h8000,   16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_POINT,   16'd0,      16'd0,      16'd0,      16'd0,      16'd0, 1'b0, 1'b0},
    // tiny square: the epsilon hides the crossing, then lets it through
    '{1'b1, KIND_SEGMENT, -16'sd16,   16'd32,     16'd1,      16'd1,      16'h0100, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, -16'sd32,   16'd32,     16'd32,     16'd32,     16'd0, 1'b0, 1'b0},
    '{1'b1, KIND_SEGMENT, -16'sd16,   16'd32,     16'd1,      16'd1,      16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_SEGMENT, -16'sd32,   16'd32,     16'd32,     16'd32,     16'd0, 1'b0, 1'b0},
    '{1'b0, KIND_POINT,   -16'sd16,   16'd32,     16'd0,      16'd0,      16'd0, 1'b0, 1'b0}
  };

  segment_square_hit_test_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .p0_x_i      (p0_x_i),
    .p0_y_i      (p0_y_i),
    .p1_x_i      (p1_x_i),
    .p1_y_i      (p1_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic bit within_unit(longint num, longint det, bit pos);
    if (pos) return num >= 0 && num <= det;
    return num <= 0 && num >= det;
  endfunction

  // cross-product test of segment a-b against edge ka-kb, no division
  function automatic bit crosses_edge(longint ax, longint ay, longint bx, longint by,
                                      longint kax, longint kay, longint kbx, longint kby);
    longint vpx, vpy, vkx, vky, dx, dy, det, ns, nt;
    vpx = bx - ax;
    vpy = by - ay;
    vkx = kbx - kax;
    vky = kby - kay;
    dx  = ax - kax;
    dy  = ay - kay;
    det = vkx * vpy - vpx * vky;
    ns  = dx * vpy - dy * vpx;
    nt  = dx * vky - dy * vkx;
    if (det <= obst_eps && det >= -obst_eps) return 1'b0;
    return within_unit(ns, det, det > 0) && within_unit(nt, det, det > 0);
  endfunction

  function automatic bit predict_hit(query_kind_e k, logic signed [COORD_W-1:0] x0,
                                     logic signed [COORD_W-1:0] y0,
                                     logic signed [COORD_W-1:0] x1,
                                     logic signed [COORD_W-1:0] y1);
    longint corner_x [4];
    longint corner_y [4];
    bit     hit;
    int     prev;
    if (k == KIND_POINT)
      return x0 < obst_cx + obst_ph && y0 < obst_cy + obst_ph &&
             x0 > obst_cx - obst_ph && y0 > obst_cy - obst_ph;
    // corners counterclockwise from lower left; edges left, bottom, right, top
    corner_x[0] = obst_cx - obst_eh;  corner_y[0] = obst_cy - obst_eh;
    corner_x[1] = obst_cx + obst_eh;  corner_y[1] = obst_cy - obst_eh;
    corner_x[2] = obst_cx + obst_eh;  corner_y[2] = obst_cy + obst_eh;
    corner_x[3] = obst_cx - obst_eh;  corner_y[3] = obst_cy + obst_eh;
    hit  = 1'b0;
    prev = 3;
    for (int i = 0; i < sqhit_pkg::NUM_EDGES && !hit; i++) begin
      hit  = crosses_edge(x0, y0, x1, y1, corner_x[prev], corner_y[prev],
                          corner_x[i], corner_y[i]);
      prev = i;
    end
    return hit;
  endfunction

  // ------------------------------------------------------------ stimulus side

  function automatic logic [COORD_W-1:0] near_coord(longint c, longint h);
    case ($urandom_range(0, 3))
      0:       return COORD_W'(c - h);
      1:       return COORD_W'(c + h);
      default: return COORD_W'(c - 2 * h - 64 +
                               longint'($urandom_range(0, 32'(4 * h + 128))));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_half();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'h7fff;
      2:       return COORD_W'($urandom_range(1, 16));
      default: return COORD_W'($urandom_range(16, 2000));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_epsilon();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'hffff;
      2:       return COORD_W'($urandom_range(1, 4095));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(sqhit_pkg::cfg_reg_e idx, logic [COORD_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      sqhit_pkg::REG_CENTER_X:         obst_cx  = longint'($signed(value));
      sqhit_pkg::REG_CENTER_Y:         obst_cy  = longint'($signed(value));
      sqhit_pkg::REG_POINT_HALF:       obst_ph  = longint'(value[sqhit_pkg::HALF_W-1:0]);
      sqhit_pkg::REG_EDGE_HALF:        obst_eh  = longint'(value[sqhit_pkg::HALF_W-1:0]);
      sqhit_pkg::REG_PARALLEL_EPSILON: obst_eps = longint'(value[sqhit_pkg::EPS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_obstacle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                  logic [COORD_W-1:0] ph, logic [COORD_W-1:0] eh,
                                  logic [COORD_W-1:0] eps);
    write_reg(sqhit_pkg::REG_CENTER_X, cx);
    write_reg(sqhit_pkg::REG_CENTER_Y, cy);
    write_reg(sqhit_pkg::REG_POINT_HALF, ph);
    write_reg(sqhit_pkg::REG_EDGE_HALF, eh);
    write_reg(sqhit_pkg::REG_PARALLEL_EPSILON, eps);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain_queries();
    in_valid_i <= 1'b0;
    while (hit_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic maybe_pause();
    if (quiet_tail) return;
    if (send_calm > 0) begin
      send_calm--;
      return;
    end
    case ($urandom_range(0, 9))
      0: send_calm = $urandom_range(10, 40);
      1, 2: begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge where the transaction happens
  task automatic send_query(query_kind_e k, logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                            logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                            bit typed, bit typed_hit);
    in_valid_i <= 1'b1;
    kind_i     <= k;
    p0_x_i     <= x0;
    p0_y_i     <= y0;
    p1_x_i     <= x1;
    p1_y_i     <= y1;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    hit_expected_q.push_back(typed ? typed_hit : predict_hit(k, x0, y0, x1, y1));
  endtask

  initial begin : stimulus
    logic [COORD_W-1:0] cx, cy, ph, eh, eps;
    logic [COORD_W-1:0] x0, y0, x1, y1;
    query_kind_e        k;
    longint             h;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = sqhit_pkg::REG_CENTER_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i     = KIND_SEGMENT;
    p0_x_i     = '0;
    p0_y_i     = '0;
    p1_x_i     = '0;
    p1_y_i     = '0;
    obst_cx    = 0;
    obst_cy    = 0;
    obst_ph    = 0;
    obst_eh    = 0;
    obst_eps   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_setup) begin
        drain_queries();
        program_obstacle(directed_plan[i].a, directed_plan[i].b, directed_plan[i].c,
                         directed_plan[i].d, directed_plan[i].e);
      end else begin
        maybe_pause();
        send_query(directed_plan[i].kind, directed_plan[i].a, directed_plan[i].b,
                   directed_plan[i].c, directed_plan[i].d,
                   directed_plan[i].typed, directed_plan[i].hit);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_queries();
      case (phase)
        0: begin
          cx = 16'd40;     cy = -16'sd24;   ph = 16'd200;    eh = 16'd198;    eps = '0;
        end
        1: begin
          cx = 16'h8000;   cy = 16'h7fff;   ph = 16'h7fff;   eh = '0;         eps = '0;
        end
        2: begin
          cx = 16'h7fff;   cy = 16'h8000;   ph = '0;         eh = 16'h7fff;   eps = 16'hffff;
        end
        default: begin
          cx  = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom :
                         $urandom_range(0, 4000) - 2000);
          cy  = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom :
                         $urandom_range(0, 4000) - 2000);
          ph  = pick_half();
          eh  = pick_half();
          eps = pick_epsilon();
        end
      endcase
      program_obstacle(cx, cy, ph, eh, eps);
      if (phase == NUM_PHASES - 1) quiet_tail = 1'b1;

      repeat (PHASE_QUERIES) begin
        k = ($urandom_range(0, 9) < 7) ? KIND_SEGMENT : KIND_POINT;
        if ($urandom_range(0, 6) == 0) begin
          // unconstrained: covers every bit of every field
          k  = query_kind_e'($urandom_range(0, 1));
          x0 = COORD_W'($urandom);
          y0 = COORD_W'($urandom);
          x1 = COORD_W'($urandom);
          y1 = COORD_W'($urandom);
        end else begin
          h  = (k == KIND_POINT) ? obst_ph : obst_eh;
          x0 = near_coord(obst_cx, h);
          y0 = near_coord(obst_cy, h);
          x1 = near_coord(obst_cx, h);
          y1 = near_coord(obst_cy, h);
          if (k == KIND_SEGMENT && $urandom_range(0, 15) == 0) begin
            x1 = x0;
            y1 = y0;
          end
        end
        maybe_pause();
        send_query(k, x0, y0, x1, y1, 1'b0, 1'b0);
      end
    end

    drain_queries();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ------------------------------------------------------------- result side

  initial begin : result_side
    int stall_left;
    int calm_left;
    bit held;
    stall_left  = 0;
    calm_left   = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        // long hold-off so the pipeline backs up into the input
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (quiet_tail || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            calm_left = $urandom_range(20, 80);
            out_ready_i <= 1'b1;
          end
          1, 2: begin
            stall_left = $urandom_range(0, 12);
            out_ready_i <= 1'b0;
          end
          default: out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  task automatic note_mismatch(string what, bit expv, logic actv);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected hit=%0b, got hit=%0b", $time, what, expv, actv);
  endtask

  // sampled mid-cycle; the transaction completes at the next rising edge
  always @(negedge clk_i) begin
    bit expv;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (hit_expected_q.size() == 0) begin
        note_mismatch("result with no query outstanding", 1'b0, hit_o);
      end else begin
        expv = hit_expected_q.pop_front();
        if (hit_o !== expv) note_mismatch("hit mismatch", expv, hit_o);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sqhit_pkg.sv
sv/segment_square_hit_test_core.sv
dv/testbench.sv
